[hw/rtl/wave_grid_stencil_step_defines.svh]
// Assertion macros shared by the wave grid stencil step block.
`ifndef WAVE_GRID_STENCIL_STEP_DEFINES_SVH
`define WAVE_GRID_STENCIL_STEP_DEFINES_SVH

// Checks that a condition implies a consequence on the same clock edge.
`define WGS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence on the next clock edge.
`define WGS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/wgs_pkg.sv]
// Package with types, constants and helper functions of the wave grid stencil step block.
`timescale 1ns / 1ps
package wgs_pkg;
	localparam int GRID_SIZE = 128;
	localparam int CW = $clog2(GRID_SIZE);
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int AW = 2 * CW;

	localparam logic [1:0] CMD_DISTURB = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_BARRIER = 2'd1;
	localparam logic [1:0] REG_SLIT = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISTURB,
		ST_READ,
		ST_FIELD,
		ST_PASS_A,
		ST_PASS_B,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Sweep operations that the datapath performs on the cell under the address.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_DISTURB,
		OP_READ,
		OP_FIELD,
		OP_DIFF1,
		OP_DIFF2
	} op_t;

	typedef struct packed {
		op_t op;
		logic axis;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic idle;
		logic result_valid;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// Half difference, rounded toward minus infinity; the result always fits in 32 bits.
	function automatic logic signed [31:0] half_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32:1];
	endfunction
endpackage

[hw/rtl/wgs_datapath.sv]
// Datapath of the wave grid stencil step block: grid memories, scaling and saturation.
`timescale 1ns / 1ps
module wgs_datapath (
	input logic clk,
	input logic arst_n,
	input wgs_pkg::cmd_t cmd_c,
	input logic [15:0] time_step,
	input logic [6:0] barrier_column,
	input logic [6:0] slit_half_width,
	input logic signed [15:0] amp,
	output logic signed [31:0] field_value,
	output logic signed [31:0] rate_value
);
	import wgs_pkg::*;

	logic signed [31:0] field_mem [CELLS];
	logic signed [31:0] rate_mem [CELLS];
	logic signed [31:0] scratch_mem [CELLS];

	// Stage 1: register command and read the memories.
	cmd_t c_s1;
	logic wr_s1;
	logic signed [31:0] f_s1, r_s1, fm_s1, sp_s1, sm_s1;
	// Stage 2: multiply result.
	cmd_t c_s2;
	logic wr_s2;
	logic signed [31:0] f_s2, r_s2, d_s2;
	logic signed [48:0] p_s2;

	function automatic logic is_wr(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [6:0] bc, input logic [6:0] h);
		logic ok;
		logic signed [CW+1:0] lo, hi, yy;
		lo = (CW+2)'(GRID_SIZE / 2) - (CW+2)'(h);
		hi = (CW+2)'(GRID_SIZE / 2) + (CW+2)'(h);
		yy = (CW+2)'(y);
		ok = (x != '0) && (x != CW'(GRID_SIZE - 1)) && (y != '0) && (y != CW'(GRID_SIZE - 1));
		if ((CW+2)'(x) == (CW+2)'(bc) && (yy <= lo || yy >= hi)) ok = 1'b0;
		return ok;
	endfunction

	logic [AW-1:0] a_c, ap_c, am_c, fa_c;
	logic [CW-1:0] xp, xm, yp, ym;
	always_comb begin
		xp = cmd_c.x + 1'b1;
		xm = cmd_c.x - 1'b1;
		yp = cmd_c.y + 1'b1;
		ym = cmd_c.y - 1'b1;
		a_c = {cmd_c.x, cmd_c.y};
		ap_c = cmd_c.axis ? {xp, cmd_c.y} : {cmd_c.x, yp};
		am_c = cmd_c.axis ? {xm, cmd_c.y} : {cmd_c.x, ym};
		// The field has two read ports: the first pass reads both neighbors,
		// every other operation reads the cell itself.
		fa_c = (cmd_c.op == OP_DIFF1) ? ap_c : a_c;
	end

	always_ff @(posedge clk) begin
		f_s1 <= field_mem[fa_c];
		r_s1 <= rate_mem[a_c];
		fm_s1 <= field_mem[am_c];
		sp_s1 <= scratch_mem[ap_c];
		sm_s1 <= scratch_mem[am_c];
		wr_s1 <= is_wr(cmd_c.x, cmd_c.y, barrier_column, slit_half_width);
		c_s1 <= cmd_c;
	end

	logic signed [31:0] mul_in;
	always_comb begin
		case (c_s1.op)
			OP_FIELD: mul_in = r_s1;
			OP_DIFF2: mul_in = half_diff(sp_s1, sm_s1);
			default: mul_in = f_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		c_s2 <= c_s1;
		wr_s2 <= wr_s1;
		f_s2 <= f_s1;
		r_s2 <= r_s1;
		d_s2 <= wr_s1 ? half_diff(f_s1, fm_s1) : 32'sd0;
		p_s2 <= 49'(mul_in) * $signed({33'd0, time_step}) + 49'sd32768;
	end

	logic signed [31:0] sc;
	assign sc = sat32(34'(p_s2 >>> 16));

	always_ff @(posedge clk) begin
		case (c_s2.op)
			OP_CLEAR: begin
				field_mem[{c_s2.x, c_s2.y}] <= '0;
				rate_mem[{c_s2.x, c_s2.y}] <= '0;
			end
			OP_DISTURB:
				if (wr_s2) field_mem[{c_s2.x, c_s2.y}] <= {amp, 16'd0};
			OP_FIELD:
				field_mem[{c_s2.x, c_s2.y}] <= sat32(34'(f_s2) + 34'(sc));
			OP_DIFF1:
				scratch_mem[{c_s2.x, c_s2.y}] <= d_s2;
			OP_DIFF2:
				if (wr_s2) rate_mem[{c_s2.x, c_s2.y}] <= sat32(34'(r_s2) + 34'(sc));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_value <= '0;
			rate_value <= '0;
		end else if (c_s2.capture) begin
			field_value <= (c_s2.op == OP_READ) ? f_s2 : 32'sd0;
			rate_value <= (c_s2.op == OP_READ) ? r_s2 : 32'sd0;
		end
	end
endmodule

[hw/rtl/wgs_control.sv]
// Controller state machine that sequences the sweeps of the wave grid stencil step block.
`timescale 1ns / 1ps
module wgs_control (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [1:0] cmd,
	input logic [6:0] pos_x,
	input logic [6:0] pos_y,
	input logic [7:0] rect_width,
	input logic [7:0] rect_length,
	input logic out_fire,
	output wgs_pkg::cmd_t cmd_c,
	output wgs_pkg::status_t status
);
	import wgs_pkg::*;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic [CW:0] i_q, i_d, j_q, j_d;
	logic [7:0] w_q, l_q;
	logic [CW-1:0] px_q, py_q;
	logic signed [9:0] x0_q, y0_q;
	logic axis_q, axis_d;
	logic [1:0] drain_q, drain_d;
	logic rv_q, rv_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			axis_q <= 1'b0;
			drain_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			i_q <= i_d;
			j_q <= j_d;
			axis_q <= axis_d;
			drain_q <= drain_d;
			rv_q <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_q <= rect_width;
			l_q <= rect_length;
			px_q <= pos_x;
			py_q <= pos_y;
			x0_q <= 10'(pos_x) - 10'(rect_width >> 1);
			y0_q <= 10'(pos_y) - 10'(rect_length >> 1);
			op_q <= cmd;
		end
	end

	logic signed [9:0] dx, dy;
	logic dvalid;
	always_comb begin
		dx = x0_q + 10'(i_q);
		dy = y0_q + 10'(j_q);
		dvalid = dx >= 0 && dx < GRID_SIZE && dy >= 0 && dy < GRID_SIZE;
	end

	logic sweep_end;
	assign sweep_end = (i_q == (CW+1)'(GRID_SIZE - 1)) && (j_q == (CW+1)'(GRID_SIZE - 1));

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		i_d = i_q;
		j_d = j_q;
		axis_d = axis_q;
		drain_d = drain_q;
		rv_d = rv_q;
		cmd_c = '0;
		cmd_c.op = OP_NONE;
		cmd_c.x = i_q[CW-1:0];
		cmd_c.y = j_q[CW-1:0];
		cmd_c.axis = axis_q;
		status.idle = (state_q == ST_IDLE);
		status.result_valid = rv_q;
		if (out_fire) rv_d = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd_c.op = OP_CLEAR;
				if (sweep_end) begin
					i_d = '0; j_d = '0;
					drain_d = 2'd3;
					ret_d = ST_IDLE;
					state_d = ST_DRAIN;
				end else if (j_q == (CW+1)'(GRID_SIZE - 1)) begin
					j_d = '0; i_d = i_q + 1'b1;
				end else j_d = j_q + 1'b1;
			end
			ST_IDLE: begin
				if (in_fire) begin
					i_d = '0; j_d = '0; axis_d = 1'b0;
					case (cmd)
						CMD_DISTURB: state_d = ST_DISTURB;
						CMD_STEP: state_d = ST_FIELD;
						default: state_d = ST_READ;
					endcase
				end
			end
			ST_READ: begin
				// The output registers are reloaded only once the waiting item is taken.
				if (!rv_q || out_fire) begin
					cmd_c.op = (op_q == CMD_READ) ? OP_READ : OP_NONE;
					cmd_c.x = px_q;
					cmd_c.y = py_q;
					cmd_c.capture = 1'b1;
					drain_d = 2'd2;
					ret_d = ST_RESULT;
					state_d = ST_DRAIN;
				end
			end
			ST_DISTURB: begin
				if (w_q == 8'd0 || l_q == 8'd0) begin
					state_d = ST_READ;
				end else begin
					cmd_c.op = dvalid ? OP_DISTURB : OP_NONE;
					cmd_c.x = dx[CW-1:0];
					cmd_c.y = dy[CW-1:0];
					if (9'(j_q) + 9'd1 < 9'(l_q)) j_d = j_q + 1'b1;
					else begin
						j_d = '0; i_d = i_q + 1'b1;
						if (9'(i_q) + 9'd1 >= 9'(w_q)) state_d = ST_READ;
					end
				end
			end
			ST_FIELD, ST_PASS_A, ST_PASS_B: begin
				cmd_c.op = (state_q == ST_FIELD) ? OP_FIELD :
					(state_q == ST_PASS_A) ? OP_DIFF1 : OP_DIFF2;
				if (sweep_end) begin
					i_d = '0; j_d = '0;
					drain_d = 2'd3;
					state_d = ST_DRAIN;
					// Step order: field, then passes A and B along y, then along x.
					case (state_q)
						ST_FIELD: ret_d = ST_PASS_A;
						ST_PASS_A: ret_d = ST_PASS_B;
						default: begin
							if (axis_q) ret_d = ST_READ;
							else begin
								ret_d = ST_PASS_A;
								axis_d = 1'b1;
							end
						end
					endcase
				end else if (j_q == (CW+1)'(GRID_SIZE - 1)) begin
					j_d = '0; i_d = i_q + 1'b1;
				end else j_d = j_q + 1'b1;
			end
			ST_DRAIN: begin
				// Wait for writes in flight before the next sweep reads them.
				if (drain_q == 2'd0) state_d = ret_q;
				else drain_d = drain_q - 1'b1;
			end
			ST_RESULT: begin
				rv_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[hw/rtl/wave_grid_stencil_step.sv]
// Top level of the wave grid stencil step block.
// channel | direction | fields
// in      | sink      | cmd pos_x pos_y rect_width rect_length amplitude
// out     | source    | field_value rate_value
// cfg     | write     | cfg_we cfg_index cfg_data
// After reset a clearing pass over all GRID_SIZE squared cells (16384) and a drain run first.
// A step runs five sweeps over all GRID_SIZE squared cells (field, then four stencil passes),
// each followed by a drain.
// One item is worked at a time; a new item may be accepted while a result waits,
// and the next result is held back until that one is taken.
`timescale 1ns / 1ps
`include "wave_grid_stencil_step_defines.svh"
module wave_grid_stencil_step (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [6:0] pos_x,
	input logic [6:0] pos_y,
	input logic [7:0] rect_width,
	input logic [7:0] rect_length,
	input logic signed [15:0] amplitude,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] field_value,
	output logic signed [31:0] rate_value,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import wgs_pkg::*;

	logic [15:0] time_step_q;
	logic [6:0] barrier_q, slit_q;
	logic signed [15:0] amp_q;
	cmd_t cmd_c;
	status_t status;
	logic out_wait;
	logic [63:0] out_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 16'd6554;
			barrier_q <= 7'd78;
			slit_q <= 7'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_BARRIER: barrier_q <= cfg_data[6:0];
				REG_SLIT: slit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign in_ready = status.idle;
	assign out_valid = status.result_valid;
	assign out_wait = out_valid && !out_ready;
	assign out_bits = {field_value, rate_value};

	always_ff @(posedge clk) if (in_valid && in_ready) amp_q <= amplitude;

	wgs_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && in_ready), .cmd(cmd),
		.pos_x(pos_x), .pos_y(pos_y), .rect_width(rect_width),
		.rect_length(rect_length), .out_fire(out_valid && out_ready),
		.cmd_c(cmd_c), .status(status)
	);

	wgs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_c(cmd_c), .time_step(time_step_q),
		.barrier_column(barrier_q), .slit_half_width(slit_q), .amp(amp_q),
		.field_value(field_value), .rate_value(rate_value)
	);

	`WGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid, "result dropped while waiting")
	`WGS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_wait, $stable(out_bits), "result changed")
	`WGS_ASSERT_NEXT(a_out_done, clk, arst_n, out_valid && out_ready, !out_valid, "result repeated")
endmodule

[test/wave_grid_stencil_step_tb.sv]
// Self-checking testbench for the wave grid stencil step block.
`timescale 1ns / 1ps
module wave_grid_stencil_step_tb;
	import wgs_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int LIMIT = 4000000;
	localparam int STEP_BUDGET = 8;

	typedef struct {
		logic [1:0] cmd;
		logic [6:0] x;
		logic [6:0] y;
		logic [7:0] w;
		logic [7:0] l;
		logic signed [15:0] amp;
	} wave_item_t;

	typedef struct {
		logic signed [31:0] fv;
		logic signed [31:0] rv;
	} cell_sample_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] cmd = 0;
	logic [6:0] pos_x = 0;
	logic [6:0] pos_y = 0;
	logic [7:0] rect_width = 0;
	logic [7:0] rect_length = 0;
	logic signed [15:0] amplitude = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] field_value;
	logic signed [31:0] rate_value;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	wave_grid_stencil_step uut (.*);

	always #2 clk = ~clk;

	// Predicted block state.
	int field_m[CELLS];
	int rate_m[CELLS];
	int diff_m[CELLS];
	int dt_m = 6554;
	int wall_m = 78;
	int slit_m = 5;

	wave_item_t pending_items[$];
	cell_sample_t expected_cells[$];
	int cycle = 0;
	int errors = 0;
	int n_steps = 0, n_disturbs = 0, n_reads = 0, n_results = 0;
	int steps_left = STEP_BUDGET;
	int last_x = 64, last_y = 64;

	function automatic int sat(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int halve(int a, int b);
		longint d;
		d = longint'(a) - longint'(b);
		return sat(d >>> 1);
	endfunction

	function automatic int scale(int v);
		longint p;
		p = longint'(v) * longint'(dt_m) + 32768;
		return sat(p >>> 16);
	endfunction

	function automatic bit open_cell(int x, int y);
		int mid;
		mid = GRID_SIZE / 2;
		if (x < 1 || x > GRID_SIZE - 2 || y < 1 || y > GRID_SIZE - 2) return 0;
		if (x == wall_m && (y <= mid - slit_m || y >= mid + slit_m)) return 0;
		return 1;
	endfunction

	task automatic apply_second_diff(bit along_x);
		int d;
		for (int x = 0; x < GRID_SIZE; x++)
			for (int y = 0; y < GRID_SIZE; y++) begin
				d = 0;
				if (open_cell(x, y))
					d = along_x ? halve(field_m[(x+1)*GRID_SIZE+y], field_m[(x-1)*GRID_SIZE+y])
						: halve(field_m[x*GRID_SIZE+y+1], field_m[x*GRID_SIZE+y-1]);
				diff_m[x*GRID_SIZE+y] = d;
			end
		for (int x = 1; x < GRID_SIZE - 1; x++)
			for (int y = 1; y < GRID_SIZE - 1; y++)
				if (open_cell(x, y)) begin
					d = along_x ? halve(diff_m[(x+1)*GRID_SIZE+y], diff_m[(x-1)*GRID_SIZE+y])
						: halve(diff_m[x*GRID_SIZE+y+1], diff_m[x*GRID_SIZE+y-1]);
					rate_m[x*GRID_SIZE+y] = sat(longint'(rate_m[x*GRID_SIZE+y]) + scale(d));
				end
	endtask

	// Updates the predicted grids for one accepted item and queues its result.
	task automatic predict_wave(wave_item_t it);
		cell_sample_t r;
		int x, y, v;
		r.fv = 0;
		r.rv = 0;
		case (it.cmd)
			CMD_DISTURB: begin
				n_disturbs++;
				v = int'(it.amp) <<< 16;
				for (int i = 0; i < int'(it.w); i++)
					for (int j = 0; j < int'(it.l); j++) begin
						x = int'(it.x) - int'(it.w) / 2 + i;
						y = int'(it.y) - int'(it.l) / 2 + j;
						if (open_cell(x, y)) field_m[x*GRID_SIZE+y] = v;
					end
			end
			CMD_STEP: begin
				n_steps++;
				for (int c = 0; c < CELLS; c++)
					field_m[c] = sat(longint'(field_m[c]) + scale(rate_m[c]));
				apply_second_diff(0);
				apply_second_diff(1);
			end
			CMD_READ: begin
				n_reads++;
				r.fv = field_m[int'(it.x)*GRID_SIZE+int'(it.y)];
				r.rv = rate_m[int'(it.x)*GRID_SIZE+int'(it.y)];
			end
			default: ;
		endcase
		expected_cells.push_back(r);
	endtask

	function automatic bool_idle_roll();
		// A calm stretch in the middle of the run keeps both sides busy.
		if (cycle > 150000 && cycle < 260000) return 0;
		return ($urandom % 100) < 32;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) predict_wave('{cmd, pos_x, pos_y, rect_width, rect_length, amplitude});
			if (pending_items.size() > 0 && !bool_idle_roll()) begin
				wave_item_t it;
				it = pending_items.pop_front();
				cmd <= it.cmd;
				pos_x <= it.x;
				pos_y <= it.y;
				rect_width <= it.w;
				rect_length <= it.l;
				amplitude <= it.amp;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			cycle <= cycle + 1;
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_cells.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result field=%0d rate=%0d",
						field_value, rate_value);
				end else begin
					cell_sample_t e;
					e = expected_cells.pop_front();
					if (e.fv !== field_value || e.rv !== rate_value) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: field exp %0d got %0d, rate exp %0d got %0d",
								e.fv, field_value, e.rv, rate_value);
					end
				end
			end
			out_ready <= !bool_idle_roll();
			if (cycle >= LIMIT) begin
				$display("timeout after %0d cycles", cycle);
				$display("wave_grid_stencil_step_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic add_item(logic [1:0] c, int x, int y, int w, int l, int a);
		wave_item_t it;
		it.cmd = c;
		it.x = 7'(x);
		it.y = 7'(y);
		it.w = 8'(w);
		it.l = 8'(l);
		it.amp = 16'(a);
		pending_items.push_back(it);
	endtask

	task automatic add_random_item();
		int r, x, y;
		r = $urandom % 100;
		x = ($urandom % 4 == 0) ? $urandom_range(0, 127) : last_x + $urandom_range(0, 8) - 4;
		y = ($urandom % 4 == 0) ? $urandom_range(0, 127) : last_y + $urandom_range(0, 8) - 4;
		x = x & 127;
		y = y & 127;
		if (r < 38) begin
			last_x = x;
			last_y = y;
			if ($urandom % 20 == 0)
				add_item(CMD_DISTURB, x, y, $urandom_range(0, 255), $urandom_range(0, 3),
					$urandom);
			else
				add_item(CMD_DISTURB, x, y, $urandom_range(0, 12), $urandom_range(0, 12),
					$urandom);
		end else if (r < 46 && steps_left > 0) begin
			steps_left--;
			add_item(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (r < 94) begin
			add_item(CMD_READ, x, y, $urandom, $urandom, $urandom);
		end else begin
			add_item(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_cells.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		case (idx)
			REG_TIME_STEP: dt_m = value & 16'hffff;
			REG_BARRIER: wall_m = value & 7'h7f;
			REG_SLIT: slit_m = value & 7'h7f;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) add_random_item();
		wait_drained();
	endtask

	initial begin
		for (int c = 0; c < CELLS; c++) begin
			field_m[c] = 0;
			rate_m[c] = 0;
			diff_m[c] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;

		add_item(CMD_READ, 0, 0, 0, 0, 0);
		add_item(CMD_READ, 127, 127, 255, 255, -1);
		add_item(CMD_DISTURB, 20, 64, 4, 4, 32767);
		add_item(CMD_DISTURB, 78, 64, 3, 20, -32768);
		add_item(CMD_DISTURB, 40, 40, 0, 5, 100);
		add_item(CMD_DISTURB, 127, 0, 255, 1, 1);
		add_item(CMD_DISTURB, 0, 0, 5, 5, -1);
		add_item(CMD_NOP, 127, 127, 255, 255, -1);
		add_item(CMD_STEP, 0, 0, 0, 0, 0);
		add_item(CMD_READ, 20, 64, 0, 0, 0);
		add_item(CMD_READ, 21, 64, 0, 0, 0);
		add_item(CMD_READ, 78, 64, 0, 0, 0);
		add_item(CMD_READ, 78, 50, 0, 0, 0);
		add_item(CMD_READ, 1, 1, 0, 0, 0);
		add_item(CMD_STEP, 127, 127, 255, 255, -1);
		add_item(CMD_READ, 19, 63, 0, 0, 0);
		add_item(CMD_READ, 77, 64, 0, 0, 0);
		add_item(CMD_DISTURB, 64, 64, 128, 128, 7);
		add_item(CMD_READ, 64, 64, 0, 0, 0);
		wait_drained();

		write_reg(REG_TIME_STEP, 65535);
		write_reg(REG_BARRIER, 1);
		write_reg(REG_SLIT, 0);
		random_phase(30);

		write_reg(REG_TIME_STEP, 0);
		write_reg(REG_BARRIER, 126);
		write_reg(REG_SLIT, 64);
		random_phase(30);

		write_reg(REG_TIME_STEP, $urandom_range(0, 65535));
		write_reg(REG_BARRIER, $urandom_range(0, 127));
		write_reg(REG_SLIT, $urandom_range(0, 127));
		random_phase(30);

		repeat (200) @(posedge clk);
		$display("covered %0d disturbs, %0d steps, %0d reads; %0d results checked",
			n_disturbs, n_steps, n_reads, n_results);
		$display("four register settings including the extremes of dt, wall and slit");
		if (errors == 0 && expected_cells.size() == 0) begin
			$display("wave_grid_stencil_step_tb: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_cells.size());
			$display("wave_grid_stencil_step_tb: FAIL");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/wgs_pkg.sv
hw/rtl/wgs_datapath.sv
hw/rtl/wgs_control.sv
hw/rtl/wave_grid_stencil_step.sv
test/wave_grid_stencil_step_tb.sv
